/* design/bqlp_pkg.sv */
// shared constants, control word layout and status types for the biquad low-pass
package bqlp_pkg;

  localparam int SAMPLE_WIDTH  = 32;
  localparam int COEF_WIDTH    = 32;
  localparam int COEF_FRAC     = COEF_WIDTH - 4;
  localparam int DELAY_WIDTH   = SAMPLE_WIDTH + 8;
  localparam int NUM_COEFS     = 5;
  localparam int CFG_IDX_WIDTH = 3;

  localparam int LO_BITS       = 16;
  localparam int HI_BITS       = DELAY_WIDTH - LO_BITS;
  localparam int PROD_WIDTH    = DELAY_WIDTH + COEF_WIDTH;
  localparam int TERM_WIDTH    = PROD_WIDTH - COEF_FRAC;
  localparam int ACC_WIDTH     = TERM_WIDTH + 2;

  localparam int DIV_NUM_WIDTH = SAMPLE_WIDTH + COEF_FRAC;
  localparam int DEN_WIDTH     = COEF_WIDTH + 2;
  localparam int DIV_CNT_WIDTH = $clog2(DIV_NUM_WIDTH);

  localparam int STEP_WIDTH    = 5;

  localparam logic [COEF_WIDTH-1:0] COEF_B0_RESET = COEF_WIDTH'(1) << COEF_FRAC;

  // coefficient register indexes
  localparam logic [CFG_IDX_WIDTH-1:0] CF_B0 = 3'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] CF_B1 = 3'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] CF_B2 = 3'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] CF_A1 = 3'd3;
  localparam logic [CFG_IDX_WIDTH-1:0] CF_A2 = 3'd4;

  // sequencer ops
  localparam logic [2:0] SQ_NEXT     = 3'd0;
  localparam logic [2:0] SQ_WAIT_IN  = 3'd1;
  localparam logic [2:0] SQ_JNOP     = 3'd2;
  localparam logic [2:0] SQ_WAIT_DIV = 3'd3;
  localparam logic [2:0] SQ_WAIT_OUT = 3'd4;

  // multiplier ops
  localparam logic [1:0] MUL_NONE = 2'd0;
  localparam logic [1:0] MUL_LO   = 2'd1;
  localparam logic [1:0] MUL_HI   = 2'd2;

  // multiplier operand select
  localparam logic [1:0] OPND_D1 = 2'd0;
  localparam logic [1:0] OPND_D2 = 2'd1;
  localparam logic [1:0] OPND_W  = 2'd2;

  // accumulator ops
  localparam logic [2:0] ACC_NONE   = 3'd0;
  localparam logic [2:0] ACC_LOAD_X = 3'd1;
  localparam logic [2:0] ACC_SUB    = 3'd2;
  localparam logic [2:0] ACC_ADD    = 3'd3;
  localparam logic [2:0] ACC_LOAD   = 3'd4;

  // datapath actions
  localparam logic [2:0] ACT_NONE      = 3'd0;
  localparam logic [2:0] ACT_LOAD_IN   = 3'd1;
  localparam logic [2:0] ACT_DIV_START = 3'd2;
  localparam logic [2:0] ACT_PRELOAD   = 3'd3;
  localparam logic [2:0] ACT_W         = 3'd4;
  localparam logic [2:0] ACT_OUT       = 3'd5;

  typedef struct packed {
    logic [2:0]               seq_op;
    logic [STEP_WIDTH-1:0]    target;
    logic [1:0]               mul_op;
    logic [1:0]               opnd;
    logic [CFG_IDX_WIDTH-1:0] coef;
    logic [2:0]               acc_op;
    logic [2:0]               act;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic op;
    logic div_busy;
    logic out_free;
  } stat_t;

endpackage

/* design/bqlp_div.sv */
// restoring divider, one quotient bit per cycle, unsigned operands
module bqlp_div (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic [bqlp_pkg::DIV_NUM_WIDTH-1:0]    num,
  input  logic [bqlp_pkg::DEN_WIDTH-1:0]        den,
  output logic                                  busy,
  output logic [bqlp_pkg::DIV_NUM_WIDTH-1:0]    quo
);
  import bqlp_pkg::*;

  logic [DEN_WIDTH-1:0]     rem;
  logic [DEN_WIDTH-1:0]     den_q;
  logic [DIV_CNT_WIDTH-1:0] cnt;
  logic [DEN_WIDTH:0]       rem_sh;
  logic [DEN_WIDTH:0]       diff;
  logic                     qbit;
  logic [DEN_WIDTH-1:0]     rem_next;

  always_comb begin
    rem_sh   = {rem, quo[DIV_NUM_WIDTH-1]};
    diff     = rem_sh - {1'b0, den_q};
    qbit     = rem_sh >= {1'b0, den_q};
    rem_next = qbit ? diff[DEN_WIDTH-1:0] : rem_sh[DEN_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == '0) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      den_q <= den;
      quo   <= num;
      cnt   <= DIV_CNT_WIDTH'(DIV_NUM_WIDTH - 1);
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[DIV_NUM_WIDTH-2:0], qbit};
      cnt <= cnt - 1'b1;
    end
  end

endmodule

/* design/bqlp_seq.sv */
// step counter and microcode rom of the biquad control program
module bqlp_seq (
  input  logic            clk,
  input  logic            rst,
  input  bqlp_pkg::stat_t stat,
  output bqlp_pkg::ctrl_t ctrl,
  output logic            go,
  output logic            in_stall
);
  import bqlp_pkg::*;

  logic [STEP_WIDTH-1:0] step;
  logic [STEP_WIDTH-1:0] step_next;

  function automatic ctrl_t cw(input logic [2:0] sq, input logic [STEP_WIDTH-1:0] tgt,
                               input logic [1:0] mo, input logic [1:0] od,
                               input logic [CFG_IDX_WIDTH-1:0] cf,
                               input logic [2:0] ao, input logic [2:0] ac);
    ctrl_t c;
    c.seq_op = sq;
    c.target = tgt;
    c.mul_op = mo;
    c.opnd   = od;
    c.coef   = cf;
    c.acc_op = ao;
    c.act    = ac;
    return c;
  endfunction

  always_comb begin
    unique case (step)
      5'd0:  ctrl = cw(SQ_WAIT_IN,  5'd0, MUL_NONE, OPND_D1, CF_B0, ACC_NONE,   ACT_LOAD_IN);
      5'd1:  ctrl = cw(SQ_JNOP,     5'd5, MUL_NONE, OPND_D1, CF_B0, ACC_NONE,   ACT_NONE);
      5'd2:  ctrl = cw(SQ_NEXT,     5'd0, MUL_NONE, OPND_D1, CF_B0, ACC_NONE,   ACT_DIV_START);
      5'd3:  ctrl = cw(SQ_WAIT_DIV, 5'd0, MUL_NONE, OPND_D1, CF_B0, ACC_NONE,   ACT_NONE);
      5'd4:  ctrl = cw(SQ_NEXT,     5'd0, MUL_NONE, OPND_D1, CF_B0, ACC_NONE,   ACT_PRELOAD);
      5'd5:  ctrl = cw(SQ_NEXT,     5'd0, MUL_LO,   OPND_D1, CF_A1, ACC_LOAD_X, ACT_NONE);
      5'd6:  ctrl = cw(SQ_NEXT,     5'd0, MUL_HI,   OPND_D1, CF_A1, ACC_NONE,   ACT_NONE);
      5'd7:  ctrl = cw(SQ_NEXT,     5'd0, MUL_LO,   OPND_D2, CF_A2, ACC_SUB,    ACT_NONE);
      5'd8:  ctrl = cw(SQ_NEXT,     5'd0, MUL_HI,   OPND_D2, CF_A2, ACC_NONE,   ACT_NONE);
      5'd9:  ctrl = cw(SQ_NEXT,     5'd0, MUL_NONE, OPND_D1, CF_B0, ACC_SUB,    ACT_NONE);
      5'd10: ctrl = cw(SQ_NEXT,     5'd0, MUL_NONE, OPND_D1, CF_B0, ACC_NONE,   ACT_W);
      5'd11: ctrl = cw(SQ_NEXT,     5'd0, MUL_LO,   OPND_W,  CF_B0, ACC_NONE,   ACT_NONE);
      5'd12: ctrl = cw(SQ_NEXT,     5'd0, MUL_HI,   OPND_W,  CF_B0, ACC_NONE,   ACT_NONE);
      5'd13: ctrl = cw(SQ_NEXT,     5'd0, MUL_LO,   OPND_D1, CF_B1, ACC_LOAD,   ACT_NONE);
      5'd14: ctrl = cw(SQ_NEXT,     5'd0, MUL_HI,   OPND_D1, CF_B1, ACC_NONE,   ACT_NONE);
      5'd15: ctrl = cw(SQ_NEXT,     5'd0, MUL_LO,   OPND_D2, CF_B2, ACC_ADD,    ACT_NONE);
      5'd16: ctrl = cw(SQ_NEXT,     5'd0, MUL_HI,   OPND_D2, CF_B2, ACC_NONE,   ACT_NONE);
      5'd17: ctrl = cw(SQ_NEXT,     5'd0, MUL_NONE, OPND_D1, CF_B0, ACC_ADD,    ACT_NONE);
      5'd18: ctrl = cw(SQ_WAIT_OUT, 5'd0, MUL_NONE, OPND_D1, CF_B0, ACC_NONE,   ACT_OUT);
      default: ctrl = cw(SQ_WAIT_OUT, 5'd0, MUL_NONE, OPND_D1, CF_B0, ACC_NONE, ACT_NONE);
    endcase
  end

  always_comb begin
    unique case (ctrl.seq_op)
      SQ_WAIT_IN:  go = stat.in_valid;
      SQ_WAIT_DIV: go = !stat.div_busy;
      SQ_WAIT_OUT: go = stat.out_free;
      default:     go = 1'b1;
    endcase
  end

  assign in_stall = ctrl.seq_op != SQ_WAIT_IN;

  always_comb begin
    step_next = step;
    if (go) begin
      unique case (ctrl.seq_op)
        SQ_JNOP:     step_next = stat.op ? step + 1'b1 : ctrl.target;
        SQ_WAIT_OUT: step_next = ctrl.target;
        default:     step_next = step + 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else begin
      step <= step_next;
    end
  end

endmodule

/* design/bqlp_dp.sv */
// coefficient registers, delays, shared multiplier, accumulator and result register
module bqlp_dp (
  input  logic                                       clk,
  input  logic                                       rst,
  input  bqlp_pkg::ctrl_t                            ctrl,
  input  logic                                       go,
  input  logic                                       cfg_write,
  input  logic [bqlp_pkg::CFG_IDX_WIDTH-1:0]         cfg_index,
  input  logic [bqlp_pkg::COEF_WIDTH-1:0]            cfg_data,
  input  logic                                       op,
  input  logic signed [bqlp_pkg::SAMPLE_WIDTH-1:0]   sample_in,
  input  logic [bqlp_pkg::DIV_NUM_WIDTH-1:0]         div_quo,
  output logic                                       div_start,
  output logic [bqlp_pkg::DIV_NUM_WIDTH-1:0]         div_num,
  output logic [bqlp_pkg::DEN_WIDTH-1:0]             div_den,
  output logic                                       op_q,
  output logic signed [bqlp_pkg::SAMPLE_WIDTH-1:0]   filtered,
  output logic                                       clipped
);
  import bqlp_pkg::*;

  logic signed [COEF_WIDTH-1:0]   coef_q [NUM_COEFS];
  logic signed [SAMPLE_WIDTH-1:0] x_q;
  logic                           clip_q;
  logic signed [DELAY_WIDTH-1:0]  d1;
  logic signed [DELAY_WIDTH-1:0]  d2;
  logic signed [DELAY_WIDTH-1:0]  w;
  logic signed [PROD_WIDTH-1:0]   prod;
  logic signed [ACC_WIDTH-1:0]    acc;
  logic                           sum_zero_q;
  logic                           q_neg_q;

  logic signed [DELAY_WIDTH-1:0]         v;
  logic signed [COEF_WIDTH-1:0]          c;
  logic signed [LO_BITS:0]               v_lo;
  logic signed [HI_BITS-1:0]             v_hi;
  logic signed [LO_BITS+COEF_WIDTH:0]    lo_prod;
  logic signed [HI_BITS+COEF_WIDTH-1:0]  hi_prod;
  logic signed [PROD_WIDTH-1:0]          hi_ext;
  logic signed [PROD_WIDTH-1:0]          prod_sh;
  logic signed [TERM_WIDTH-1:0]          term;
  logic signed [DEN_WIDTH-1:0]           gain_sum;
  logic [SAMPLE_WIDTH-1:0]               x_mag;
  logic [ACC_WIDTH-DELAY_WIDTH:0]        w_top;
  logic                                  w_fits;
  logic [ACC_WIDTH-SAMPLE_WIDTH:0]       y_top;
  logic                                  y_fits;
  logic                                  pre_ovf;
  logic signed [DELAY_WIDTH-1:0]         pre_val;

  always_comb begin
    unique case (ctrl.opnd)
      OPND_D2: v = d2;
      OPND_W:  v = w;
      default: v = d1;
    endcase
    unique case (ctrl.coef)
      CF_B0:   c = coef_q[0];
      CF_B1:   c = coef_q[1];
      CF_B2:   c = coef_q[2];
      CF_A1:   c = coef_q[3];
      CF_A2:   c = coef_q[4];
      default: c = '0;
    endcase
    v_lo    = signed'({1'b0, v[LO_BITS-1:0]});
    v_hi    = v[DELAY_WIDTH-1:LO_BITS];
    lo_prod = v_lo * c;
    hi_prod = v_hi * c;
    hi_ext  = PROD_WIDTH'(hi_prod) <<< LO_BITS;
    prod_sh = prod >>> COEF_FRAC;
    term    = prod_sh[TERM_WIDTH-1:0];
  end

  // preload divider operands
  always_comb begin
    gain_sum  = DEN_WIDTH'(coef_q[0]) + DEN_WIDTH'(coef_q[1]) + DEN_WIDTH'(coef_q[2]);
    x_mag     = x_q[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-x_q) : SAMPLE_WIDTH'(x_q);
    div_num   = {x_mag, {COEF_FRAC{1'b0}}};
    div_den   = gain_sum[DEN_WIDTH-1] ? DEN_WIDTH'(-gain_sum) : DEN_WIDTH'(gain_sum);
    div_start = go && ctrl.act == ACT_DIV_START;
  end

  always_comb begin
    if (q_neg_q) begin
      pre_ovf = (|div_quo[DIV_NUM_WIDTH-1:DELAY_WIDTH])
                || (div_quo[DELAY_WIDTH-1] && (|div_quo[DELAY_WIDTH-2:0]));
      pre_val = pre_ovf ? {1'b1, {(DELAY_WIDTH-1){1'b0}}}
                        : DELAY_WIDTH'(-signed'(div_quo[DELAY_WIDTH-1:0]));
    end else begin
      pre_ovf = |div_quo[DIV_NUM_WIDTH-1:DELAY_WIDTH-1];
      pre_val = pre_ovf ? {1'b0, {(DELAY_WIDTH-1){1'b1}}}
                        : signed'(div_quo[DELAY_WIDTH-1:0]);
    end
  end

  always_comb begin
    w_top  = acc[ACC_WIDTH-1:DELAY_WIDTH-1];
    w_fits = (&w_top) || !(|w_top);
    y_top  = acc[ACC_WIDTH-1:SAMPLE_WIDTH-1];
    y_fits = (&y_top) || !(|y_top);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_q[0] <= COEF_B0_RESET;
      coef_q[1] <= '0;
      coef_q[2] <= '0;
      coef_q[3] <= '0;
      coef_q[4] <= '0;
    end else if (cfg_write && cfg_index < CFG_IDX_WIDTH'(NUM_COEFS)) begin
      coef_q[cfg_index] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d1 <= '0;
      d2 <= '0;
    end else if (go && ctrl.act == ACT_PRELOAD) begin
      d1 <= sum_zero_q ? DELAY_WIDTH'(x_q) : pre_val;
      d2 <= sum_zero_q ? DELAY_WIDTH'(x_q) : pre_val;
    end else if (go && ctrl.act == ACT_OUT) begin
      d1 <= w;
      d2 <= d1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctrl.mul_op)
      MUL_LO:  prod <= PROD_WIDTH'(lo_prod);
      MUL_HI:  prod <= prod + hi_ext;
      default: prod <= prod;
    endcase
    case (ctrl.acc_op)
      ACC_LOAD_X: acc <= ACC_WIDTH'(x_q);
      ACC_SUB:    acc <= acc - ACC_WIDTH'(term);
      ACC_ADD:    acc <= acc + ACC_WIDTH'(term);
      ACC_LOAD:   acc <= ACC_WIDTH'(term);
      default:    acc <= acc;
    endcase
    if (go) begin
      unique case (ctrl.act)
        ACT_LOAD_IN: begin
          x_q    <= sample_in;
          op_q   <= op;
          clip_q <= 1'b0;
        end
        ACT_DIV_START: begin
          sum_zero_q <= gain_sum == '0;
          q_neg_q    <= x_q[SAMPLE_WIDTH-1] ^ gain_sum[DEN_WIDTH-1];
        end
        ACT_PRELOAD: begin
          if (!sum_zero_q && pre_ovf) begin
            clip_q <= 1'b1;
          end
        end
        ACT_W: begin
          w <= w_fits ? acc[DELAY_WIDTH-1:0] : DELAY_WIDTH'(x_q);
          if (!w_fits) begin
            clip_q <= 1'b1;
          end
        end
        ACT_OUT: begin
          if (y_fits) begin
            filtered <= acc[SAMPLE_WIDTH-1:0];
          end else begin
            filtered <= acc[ACC_WIDTH-1] ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}
                                         : {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
          end
          clipped <= clip_q || !y_fits;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

/* design/second_order_lowpass_biquad.sv */
// top level of the direct form II biquad low-pass filter
// op 0 runs 16 control steps, and a new input is taken only once the previous one has run all of its steps
// op 1 adds a bit-serial division for the delay preload plus 3 control steps
// the result register lets the next input be taken while a result waits
// reset: synchronous; coefficients go to pass-through, delays clear, no result pending
module second_order_lowpass_biquad (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      in_valid,
  output logic                                      in_stall,
  input  logic                                      op,
  input  logic signed [bqlp_pkg::SAMPLE_WIDTH-1:0]  sample_in,
  output logic                                      out_valid,
  input  logic                                      out_stall,
  output logic signed [bqlp_pkg::SAMPLE_WIDTH-1:0]  filtered,
  output logic                                      clipped,
  input  logic                                      cfg_write,
  input  logic [bqlp_pkg::CFG_IDX_WIDTH-1:0]        cfg_index,
  input  logic [bqlp_pkg::COEF_WIDTH-1:0]           cfg_data
);
  import bqlp_pkg::*;

  ctrl_t                     ctrl;
  stat_t                     stat;
  logic                      go;
  logic                      op_q;
  logic                      div_start;
  logic                      div_busy;
  logic [DIV_NUM_WIDTH-1:0]  div_num;
  logic [DEN_WIDTH-1:0]      div_den;
  logic [DIV_NUM_WIDTH-1:0]  div_quo;

  always_comb begin
    stat.in_valid = in_valid;
    stat.op       = op_q;
    stat.div_busy = div_busy;
    stat.out_free = !out_valid || !out_stall;
  end

  bqlp_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .stat     (stat),
    .ctrl     (ctrl),
    .go       (go),
    .in_stall (in_stall)
  );

  bqlp_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quo   (div_quo)
  );

  bqlp_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .go        (go),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .op        (op),
    .sample_in (sample_in),
    .div_quo   (div_quo),
    .div_start (div_start),
    .div_num   (div_num),
    .div_den   (div_den),
    .op_q      (op_q),
    .filtered  (filtered),
    .clipped   (clipped)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go && ctrl.act == ACT_OUT) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

/* test/tb_second_order_lowpass_biquad.sv */
// self-checking testbench for the direct form II biquad low-pass filter
module tb_second_order_lowpass_biquad;
  timeunit 1ns;
  timeprecision 1ps;

  import bqlp_pkg::*;

  localparam int WIDE        = 80;
  localparam int UNIT        = 1 << COEF_FRAC;
  localparam int NUM_INDEXES = 1 << CFG_IDX_WIDTH;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 400;

  localparam logic OP_FILTER  = 1'b0;
  localparam logic OP_PRELOAD = 1'b1;

  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
  localparam logic signed [COEF_WIDTH-1:0]   COEF_MAX   = {1'b0, {(COEF_WIDTH-1){1'b1}}};
  localparam logic signed [COEF_WIDTH-1:0]   COEF_MIN   = {1'b1, {(COEF_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] filtered;
    logic                           clipped;
  } biquad_out_t;

  logic                                  clk;
  logic                                  rst;
  logic                                  in_valid;
  logic                                  in_stall;
  logic                                  op;
  logic signed [SAMPLE_WIDTH-1:0]        sample_in;
  logic                                  out_valid;
  logic                                  out_stall;
  logic signed [SAMPLE_WIDTH-1:0]        filtered;
  logic                                  clipped;
  logic                                  cfg_write;
  logic [CFG_IDX_WIDTH-1:0]              cfg_index;
  logic [COEF_WIDTH-1:0]                 cfg_data;

  logic signed [COEF_WIDTH-1:0]          coef_set [NUM_COEFS];
  logic signed [DELAY_WIDTH-1:0]         tap1;
  logic signed [DELAY_WIDTH-1:0]         tap2;
  biquad_out_t                           expected_filtered [$];
  biquad_out_t                           want;

  logic no_idle;
  int   sink_hold_cycles;
  int   errors;
  int   cycle_count;
  int   n_sent;
  int   n_preload;
  int   n_checked;
  int   n_clipped;
  int   n_settings;

  second_order_lowpass_biquad i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .sample_in (sample_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .filtered  (filtered),
    .clipped   (clipped),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic signed [WIDE-1:0] clamp_to(input logic signed [WIDE-1:0] v,
                                                      input int bits, output logic hit);
    logic signed [WIDE-1:0] top;
    logic signed [WIDE-1:0] bottom;
    top    = (80'sd1 <<< (bits - 1)) - 80'sd1;
    bottom = -top - 80'sd1;
    hit    = (v > top) || (v < bottom);
    if (v > top) return top;
    if (v < bottom) return bottom;
    return v;
  endfunction

  // exact product, floored back to the sample scale
  function automatic logic signed [WIDE-1:0] coef_term(input logic signed [WIDE-1:0] v,
                                                       input logic signed [COEF_WIDTH-1:0] c);
    logic signed [WIDE-1:0] cw;
    cw = c;
    return (v * cw) >>> COEF_FRAC;
  endfunction

  function automatic biquad_out_t filter_sample(input logic kind,
                                                input logic signed [SAMPLE_WIDTH-1:0] x);
    logic signed [WIDE-1:0] xw;
    logic signed [WIDE-1:0] gain;
    logic signed [WIDE-1:0] level;
    logic signed [WIDE-1:0] w;
    logic signed [WIDE-1:0] y;
    logic [WIDE-1:0]        num_mag;
    logic [WIDE-1:0]        den_mag;
    logic                   hit;
    logic                   clip;
    biquad_out_t            res;
    clip = 1'b0;
    xw   = x;
    if (kind == OP_PRELOAD) begin
      gain  = coef_set[CF_B0] + coef_set[CF_B1] + coef_set[CF_B2];
      level = xw;
      if (gain != 0) begin
        num_mag = (xw < 0) ? -xw : xw;
        num_mag = num_mag << COEF_FRAC;
        den_mag = (gain < 0) ? -gain : gain;
        level   = num_mag / den_mag;
        if ((xw < 0) != (gain < 0)) level = -level;
        level = clamp_to(level, DELAY_WIDTH, hit);
        clip  = clip | hit;
      end
      tap1 = level[DELAY_WIDTH-1:0];
      tap2 = level[DELAY_WIDTH-1:0];
    end
    w = xw - coef_term(tap1, coef_set[CF_A1]) - coef_term(tap2, coef_set[CF_A2]);
    level = clamp_to(w, DELAY_WIDTH, hit);
    if (hit) begin
      clip = 1'b1;
      w    = xw;
    end
    y = coef_term(w, coef_set[CF_B0]) + coef_term(tap1, coef_set[CF_B1])
        + coef_term(tap2, coef_set[CF_B2]);
    y = clamp_to(y, SAMPLE_WIDTH, hit);
    clip = clip | hit;
    tap2 = tap1;
    tap1 = w[DELAY_WIDTH-1:0];
    res.filtered = y[SAMPLE_WIDTH-1:0];
    res.clipped  = clip;
    return res;
  endfunction

  function automatic logic signed [SAMPLE_WIDTH-1:0] random_sample();
    case ($urandom_range(0, 19))
      0:             return SAMPLE_MAX;
      1:             return SAMPLE_MIN;
      2:             return 0;
      3, 4, 5, 6, 7: return $urandom();
      default:       return int'($urandom_range(0, (1 << 25) - 1)) - (1 << 24);
    endcase
  endfunction

  task automatic send_sample(input logic kind, input logic signed [SAMPLE_WIDTH-1:0] x);
    int          gap;
    biquad_out_t exp_out;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    op        <= kind;
    sample_in <= x;
    do @(posedge clk); while (in_stall);
    exp_out = filter_sample(kind, x);
    expected_filtered.push_back(exp_out);
    n_sent++;
    if (kind == OP_PRELOAD) n_preload++;
    if (exp_out.clipped) n_clipped++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (expected_filtered.size() != 0);
  endtask

  task automatic write_coef(input logic [CFG_IDX_WIDTH-1:0] idx,
                            input logic [COEF_WIDTH-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
    if (idx < NUM_COEFS) coef_set[idx] = value;
  endtask

  task automatic set_coefs(input logic signed [COEF_WIDTH-1:0] b0, b1, b2, a1, a2);
    write_coef(CF_B0, b0);
    write_coef(CF_B1, b1);
    write_coef(CF_B2, b2);
    write_coef(CF_A1, a1);
    write_coef(CF_A2, a2);
    n_settings++;
  endtask

  task automatic test_passthrough();
    send_sample(OP_FILTER, 0);
    send_sample(OP_FILTER, SAMPLE_MAX);
    send_sample(OP_FILTER, SAMPLE_MIN);
    send_sample(OP_FILTER, -1);
    send_sample(OP_PRELOAD, 32'sh5555_5555);
    send_sample(OP_FILTER, 32'shAAAA_AAAA);
    send_sample(OP_FILTER, 1);
    drain_results();
  endtask

  // writes above the last coefficient must leave the filter untouched
  task automatic test_spare_index();
    for (int idx = CF_A2 + 1; idx < NUM_INDEXES; idx++) begin
      write_coef(CFG_IDX_WIDTH'(idx), $urandom());
    end
    send_sample(OP_PRELOAD, 32'sh0001_0000);
    send_sample(OP_FILTER, -32'sh0003_8000);
    drain_results();
  endtask

  task automatic test_lowpass_preload();
    set_coefs(UNIT / 16, UNIT / 8, UNIT / 16, -(UNIT + UNIT / 4), UNIT / 2);
    send_sample(OP_PRELOAD, 32'sh03E8_0000);
    send_sample(OP_FILTER, 32'sh03E8_0000);
    send_sample(OP_FILTER, SAMPLE_MIN);
    send_sample(OP_PRELOAD, SAMPLE_MIN);
    drain_results();
  endtask

  task automatic test_zero_gain();
    set_coefs(UNIT, -UNIT, 0, UNIT / 4, -(UNIT / 8));
    send_sample(OP_PRELOAD, SAMPLE_MAX);
    send_sample(OP_PRELOAD, -32'sh0000_8000);
    drain_results();
  endtask

  task automatic test_preload_saturation();
    set_coefs(1, 0, 0, 0, 0);
    send_sample(OP_PRELOAD, SAMPLE_MAX);
    send_sample(OP_PRELOAD, SAMPLE_MIN);
    drain_results();
  endtask

  task automatic test_overflow();
    set_coefs(COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MIN);
    send_sample(OP_PRELOAD, SAMPLE_MAX);
    send_sample(OP_FILTER, SAMPLE_MAX);
    send_sample(OP_FILTER, SAMPLE_MAX);
    send_sample(OP_FILTER, SAMPLE_MIN);
    send_sample(OP_FILTER, 0);
    drain_results();
  endtask

  task automatic test_random_traffic();
    int c [NUM_COEFS];
    int fb2;
    for (int phase = 0; phase < 7; phase++) begin
      case (phase % 4)
        0: begin
          fb2  = $urandom_range(UNIT / 16, (UNIT / 16) * 15);
          c[4] = fb2;
          c[3] = -int'($urandom_range(UNIT / 4, UNIT + fb2 - 1));
          c[0] = $urandom_range(1, UNIT / 4);
          c[1] = 2 * c[0];
          c[2] = c[0];
        end
        1: foreach (c[k]) c[k] = $urandom();
        2: foreach (c[k]) begin
          case ($urandom_range(0, 4))
            0:       c[k] = COEF_MIN;
            1:       c[k] = COEF_MAX;
            2:       c[k] = 0;
            3:       c[k] = UNIT;
            default: c[k] = -UNIT;
          endcase
        end
        default: foreach (c[k]) c[k] = int'($urandom_range(0, UNIT)) - UNIT / 2;
      endcase
      set_coefs(c[0], c[1], c[2], c[3], c[4]);
      for (int i = 0; i < 200; i++) begin
        if (i % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
        send_sample(($urandom_range(0, 15) == 0) ? OP_PRELOAD : OP_FILTER, random_sample());
      end
      drain_results();
    end
    no_idle = 1'b0;
  endtask

  // results back up while the sink holds off, so the input has to stall
  task automatic test_backpressure();
    no_idle          = 1'b1;
    sink_hold_cycles = HOLD_CYCLES;
    repeat (8) send_sample(OP_FILTER, random_sample());
    no_idle = 1'b0;
    drain_results();
  endtask

  initial begin : result_sink
    int wait_cycles;
    out_stall = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      wait_cycles = no_idle ? 0 : $urandom_range(0, 3);
      if (sink_hold_cycles != 0) begin
        wait_cycles      = wait_cycles + sink_hold_cycles;
        sink_hold_cycles = 0;
      end
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_filtered.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("unexpected transaction: filtered=%0d clipped=%0b", filtered, clipped);
        end
      end else begin
        want = expected_filtered.pop_front();
        n_checked++;
        if (want.filtered !== filtered || want.clipped !== clipped) begin
          errors++;
          if (errors <= 10) begin
            $display("transaction %0d: expected filtered=%0d clipped=%0b, got filtered=%0d clipped=%0b",
                     n_checked, want.filtered, want.clipped, filtered, clipped);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_filtered.size());
      $display("second_order_lowpass_biquad: mismatch");
      $finish;
    end
  end

  initial begin
    rst              = 1'b1;
    in_valid         = 1'b0;
    op               = OP_FILTER;
    sample_in        = '0;
    cfg_write        = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    no_idle          = 1'b0;
    sink_hold_cycles = 0;
    errors           = 0;
    cycle_count      = 0;
    n_sent           = 0;
    n_preload        = 0;
    n_checked        = 0;
    n_clipped        = 0;
    n_settings       = 0;
    coef_set[CF_B0]  = COEF_B0_RESET;
    coef_set[CF_B1]  = '0;
    coef_set[CF_B2]  = '0;
    coef_set[CF_A1]  = '0;
    coef_set[CF_A2]  = '0;
    tap1             = '0;
    tap2             = '0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    test_passthrough();
    test_spare_index();
    test_lowpass_preload();
    test_zero_gain();
    test_preload_saturation();
    test_overflow();
    test_random_traffic();
    test_backpressure();

    repeat (100) @(negedge clk);
    if (expected_filtered.size() != 0) begin
      $display("%0d expected results never arrived", expected_filtered.size());
      errors = errors + expected_filtered.size();
    end
    $display("%0d samples filtered (%0d with delay preload), %0d results checked, %0d clipped",
             n_sent, n_preload, n_checked, n_clipped);
    $display("%0d coefficient sets incl. extremes and zero gain, one %0d-cycle output hold",
             n_settings, HOLD_CYCLES);
    if (errors == 0) begin
      $display("second_order_lowpass_biquad: match");
    end else begin
      $display("second_order_lowpass_biquad: mismatch");
    end
    $finish;
  end

endmodule

/* sim.f */
design/bqlp_pkg.sv
design/bqlp_div.sv
design/bqlp_seq.sv
design/bqlp_dp.sv
design/second_order_lowpass_biquad.sv
test/tb_second_order_lowpass_biquad.sv
